// ===== design/ffha_pkg.sv =====
`timescale 1ns / 1ps

package ffha_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_ALLOC_FAIL   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE     = 2'd2;
    localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [12:0] request_bytes;
        logic [12:0] payload_offset_in;
    } ffha_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] payload_offset_out;
        logic [12:0] used_bytes;
        logic [12:0] free_bytes;
    } ffha_rsp_t;

endpackage

// ===== design/ffha_mem.sv =====
`timescale 1ns / 1ps

module ffha_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int EW    = 15
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [EW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [EW-1:0] rdata
);

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/first_fit_heap_allocator_top.sv =====
`timescale 1ns / 1ps

// First-fit pool allocator with coalescing. After reset the block runs a clearing pass over
// every entry of its block table, holding req_stall high. An allocate request then walks the
// blocks one by one up to the first fit; a free walks the whole chain from the first block,
// merging adjacent free blocks, as the block table memory has a single read port. Results
// wait in an output register, so one result may be held while the next runs.
module first_fit_heap_allocator_top
    import ffha_pkg::*;
#(
    parameter int POOL_BYTES   = 4096,
    parameter int HEADER_BYTES = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  ffha_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output ffha_rsp_t rsp
);

    localparam int AW    = $clog2(POOL_BYTES);
    localparam int LEN_W = $clog2(POOL_BYTES + 1);
    localparam int EW    = LEN_W + 2;
    localparam int CW    = (AW + 2 > 15) ? AW + 2 : 15;

    localparam logic [CW-1:0] HDR    = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] POOL_C = CW'(POOL_BYTES);
    localparam logic [CW-1:0] FOUR   = CW'(4);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_AWALK  = 4'd2;
    localparam logic [3:0] S_ASPLIT = 4'd3;
    localparam logic [3:0] S_FCHK   = 4'd4;
    localparam logic [3:0] S_MSTART = 4'd5;
    localparam logic [3:0] S_MLOAD  = 4'd6;
    localparam logic [3:0] S_MWALK  = 4'd7;
    localparam logic [3:0] S_MFLUSH = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [AW-1:0]    at_reg, at_next;
    logic [AW-1:0]    nx_reg, nx_next;
    logic             cur_free_reg, cur_free_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;
    logic             dirty_reg, dirty_next;
    logic [13:0]      want_reg, want_next;
    logic [1:0]       status_reg, status_next;
    logic [11:0]      offs_reg, offs_next;
    logic [LEN_W-1:0] used_reg, used_next;
    logic [LEN_W-1:0] free_reg, free_next;
    logic             rsp_valid_reg, rsp_valid_next;
    ffha_rsp_t        rsp_reg, rsp_next;

    logic          m_we;
    logic [AW-1:0] m_waddr;
    logic [EW-1:0] m_wdata;
    logic [AW-1:0] m_raddr;
    logic [EW-1:0] m_rdata;

    logic             d_start;
    logic             d_free;
    logic [LEN_W-1:0] d_len;
    logic [CW-1:0]    want_c;
    logic [CW-1:0]    have_c;
    logic [CW-1:0]    step_c;
    logic [CW-1:0]    merged_c;
    logic [CW-1:0]    off_c;

    ffha_mem #(
        .DEPTH (POOL_BYTES),
        .AW    (AW),
        .EW    (EW)
    ) u_mem (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    assign d_start = m_rdata[EW-1];
    assign d_free  = m_rdata[EW-2];
    assign d_len   = m_rdata[LEN_W-1:0];
    assign want_c  = CW'(want_reg);
    assign have_c  = CW'(d_len);
    assign off_c   = CW'(req.payload_offset_in);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        at_next        = at_reg;
        nx_next        = nx_reg;
        cur_free_next  = cur_free_reg;
        cur_len_next   = cur_len_reg;
        dirty_next     = dirty_reg;
        want_next      = want_reg;
        status_next    = status_reg;
        offs_next      = offs_reg;
        used_next      = used_reg;
        free_next      = free_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        m_we           = 1'b0;
        m_waddr        = at_reg;
        m_wdata        = '0;
        m_raddr        = at_reg;
        step_c         = CW'(at_reg) + HDR + have_c;
        merged_c       = CW'(cur_len_reg) + have_c + HDR;

        case (state_reg)
            S_CLR:
            begin
                m_we    = 1'b1;
                m_waddr = clr_reg;
                if (clr_reg == '0)
                begin
                    m_wdata = {1'b1, 1'b1, LEN_W'(POOL_BYTES - HEADER_BYTES)};
                end
                if (clr_reg == AW'(POOL_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                offs_next = '0;
                if (req_valid)
                begin
                    if (req.operation == OP_ALLOC)
                    begin
                        want_next  = ({1'b0, req.request_bytes} + 14'd3) & ~14'd3;
                        at_next    = '0;
                        m_raddr    = '0;
                        state_next = S_AWALK;
                    end
                    else if (off_c < HDR || off_c >= POOL_C)
                    begin
                        status_next = ST_BAD_FREE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        at_next    = AW'(off_c - HDR);
                        m_raddr    = AW'(off_c - HDR);
                        state_next = S_FCHK;
                    end
                end
            end
            S_AWALK:
            begin
                if (!d_start)
                begin
                    status_next = ST_ALLOC_FAIL;
                    state_next  = S_DONE;
                end
                else if (d_free && have_c >= want_c)
                begin
                    status_next = ST_OK;
                    offs_next   = 12'(CW'(at_reg) + HDR);
                    if (have_c > want_c + HDR + FOUR)
                    begin
                        m_we       = 1'b1;
                        m_waddr    = AW'(CW'(at_reg) + HDR + want_c);
                        m_wdata    = {1'b1, 1'b1, LEN_W'(have_c - want_c - HDR)};
                        used_next  = used_reg + LEN_W'(want_c);
                        free_next  = free_reg - LEN_W'(want_c + HDR);
                        state_next = S_ASPLIT;
                    end
                    else
                    begin
                        m_we       = 1'b1;
                        m_waddr    = at_reg;
                        m_wdata    = {1'b1, 1'b0, d_len};
                        used_next  = used_reg + d_len;
                        free_next  = free_reg - d_len;
                        state_next = S_DONE;
                    end
                end
                else if (step_c >= POOL_C)
                begin
                    status_next = ST_ALLOC_FAIL;
                    state_next  = S_DONE;
                end
                else
                begin
                    at_next = AW'(step_c);
                    m_raddr = AW'(step_c);
                end
            end
            S_ASPLIT:
            begin
                m_we       = 1'b1;
                m_waddr    = at_reg;
                m_wdata    = {1'b1, 1'b0, LEN_W'(want_c)};
                state_next = S_DONE;
            end
            S_FCHK:
            begin
                if (!d_start)
                begin
                    status_next = ST_BAD_FREE;
                    state_next  = S_DONE;
                end
                else if (d_free)
                begin
                    status_next = ST_ALREADY_FREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    m_we        = 1'b1;
                    m_waddr     = at_reg;
                    m_wdata     = {1'b1, 1'b1, d_len};
                    used_next   = used_reg - d_len;
                    free_next   = free_reg + d_len;
                    status_next = ST_OK;
                    state_next  = S_MSTART;
                end
            end
            S_MSTART:
            begin
                at_next    = '0;
                m_raddr    = '0;
                state_next = S_MLOAD;
            end
            S_MLOAD:
            begin
                cur_free_next = d_free;
                cur_len_next  = d_len;
                dirty_next    = 1'b0;
                if (step_c >= POOL_C)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    nx_next    = AW'(step_c);
                    m_raddr    = AW'(step_c);
                    state_next = S_MWALK;
                end
            end
            S_MWALK:
            begin
                if (!d_start)
                begin
                    m_we       = dirty_reg;
                    m_waddr    = at_reg;
                    m_wdata    = {1'b1, cur_free_reg, cur_len_reg};
                    state_next = S_DONE;
                end
                else if (cur_free_reg && d_free)
                begin
                    m_we         = 1'b1;
                    m_waddr      = nx_reg;
                    m_wdata      = '0;
                    cur_len_next = LEN_W'(merged_c);
                    dirty_next   = 1'b1;
                    free_next    = free_reg + LEN_W'(HDR);
                    if (CW'(at_reg) + HDR + merged_c >= POOL_C)
                    begin
                        state_next = S_MFLUSH;
                    end
                    else
                    begin
                        nx_next = AW'(CW'(at_reg) + HDR + merged_c);
                        m_raddr = AW'(CW'(at_reg) + HDR + merged_c);
                    end
                end
                else
                begin
                    m_we          = dirty_reg;
                    m_waddr       = at_reg;
                    m_wdata       = {1'b1, cur_free_reg, cur_len_reg};
                    at_next       = nx_reg;
                    cur_free_next = d_free;
                    cur_len_next  = d_len;
                    dirty_next    = 1'b0;
                    if (CW'(nx_reg) + HDR + have_c >= POOL_C)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        nx_next = AW'(CW'(nx_reg) + HDR + have_c);
                        m_raddr = AW'(CW'(nx_reg) + HDR + have_c);
                    end
                end
            end
            S_MFLUSH:
            begin
                m_we       = 1'b1;
                m_waddr    = at_reg;
                m_wdata    = {1'b1, cur_free_reg, cur_len_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_next.status            = status_reg;
                    rsp_next.payload_offset_out = offs_reg;
                    rsp_next.used_bytes        = 13'(used_reg);
                    rsp_next.free_bytes        = 13'(free_reg);
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            dirty_reg     <= 1'b0;
            used_reg      <= '0;
            free_reg      <= LEN_W'(POOL_BYTES - HEADER_BYTES);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            dirty_reg     <= dirty_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        at_reg       <= at_next;
        nx_reg       <= nx_next;
        cur_free_reg <= cur_free_next;
        cur_len_reg  <= cur_len_next;
        want_reg     <= want_next;
        status_reg   <= status_next;
        offs_reg     <= offs_next;
        rsp_reg      <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (CW'(used_reg) + CW'(free_reg) <= POOL_C))
        else $error("used plus free totals exceed pool size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |-> (rsp.payload_offset_out == 12'd0))
        else $error("failed request carries a payload offset");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second request taken while one is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> (m_we && !rsp_valid))
        else $error("clearing pass skipped a table entry");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ffha_pkg::*;

    localparam int POOL   = 4096;
    localparam int HEADER = 12;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    ffha_req_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    ffha_rsp_t rsp;

    first_fit_heap_allocator_top #(.POOL_BYTES(POOL), .HEADER_BYTES(HEADER)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    bit          is_start [POOL];
    int unsigned blk_len  [POOL];
    bit          is_free  [POOL];

    ffha_rsp_t   pending_rsp[$];
    int unsigned live_offsets[$];
    int          error_count;
    int          send_idle_pct;
    int          stall_pct;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        error_count++;
    endtask

    function automatic void pool_reset();
        for (int i = 0; i < POOL; i++)
        begin
            is_start[i] = 0;
            blk_len[i]  = 0;
            is_free[i]  = 0;
        end
        is_start[0] = 1;
        blk_len[0]  = POOL - HEADER;
        is_free[0]  = 1;
    endfunction

    function automatic void coalesce();
        int unsigned at;
        int unsigned nx;
        at = 0;
        while (at < POOL)
        begin
            nx = at + HEADER + blk_len[at];
            if (nx >= POOL || !is_start[nx])
                break;
            if (is_free[at] && is_free[nx])
            begin
                blk_len[at] += blk_len[nx] + HEADER;
                is_start[nx] = 0;
                is_free[nx]  = 0;
                blk_len[nx]  = 0;
            end
            else
                at = nx;
        end
    endfunction

    function automatic ffha_rsp_t predict_heap(input ffha_req_t r);
        ffha_rsp_t   o;
        int unsigned want, at, have, cut, used, avail, off;
        o = '0;
        if (r.operation == OP_ALLOC)
        begin
            o.status = ST_ALLOC_FAIL;
            want = (int'(r.request_bytes) + 3) & ~3;
            at = 0;
            while (at < POOL && is_start[at])
            begin
                have = blk_len[at];
                if (is_free[at] && have >= want)
                begin
                    if (have > want + HEADER + 4)
                    begin
                        cut = at + HEADER + want;
                        if (cut < POOL)
                        begin
                            is_start[cut] = 1;
                            is_free[cut]  = 1;
                            blk_len[cut]  = have - want - HEADER;
                            blk_len[at]   = want;
                        end
                    end
                    is_free[at] = 0;
                    o.status = ST_OK;
                    o.payload_offset_out = 12'(at + HEADER);
                    break;
                end
                at = at + HEADER + blk_len[at];
            end
        end
        else
        begin
            off = r.payload_offset_in;
            if (off < HEADER || off >= POOL || !is_start[off - HEADER])
                o.status = ST_BAD_FREE;
            else if (is_free[off - HEADER])
                o.status = ST_ALREADY_FREE;
            else
            begin
                is_free[off - HEADER] = 1;
                coalesce();
                o.status = ST_OK;
            end
        end
        used = 0;
        avail = 0;
        at = 0;
        while (at < POOL && is_start[at])
        begin
            if (is_free[at])
                avail += blk_len[at];
            else
                used += blk_len[at];
            at = at + HEADER + blk_len[at];
        end
        o.used_bytes = 13'(used);
        o.free_bytes = 13'(avail);
        return o;
    endfunction

    task automatic send_request(input logic op, input int unsigned bytes, input int unsigned off);
        ffha_req_t r;
        ffha_rsp_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        r.operation = op;
        r.request_bytes = 13'(bytes);
        r.payload_offset_in = 13'(off);
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        p = predict_heap(r);
        pending_rsp.push_back(p);
        if (op == OP_ALLOC && p.status == ST_OK)
            live_offsets.push_back(p.payload_offset_out);
    endtask

    task automatic send_alloc(input int unsigned bytes);
        send_request(OP_ALLOC, bytes, $urandom_range(8191));
    endtask

    task automatic send_free(input int unsigned off);
        send_request(OP_FREE, $urandom_range(8191), off);
    endtask

    task automatic free_random_live();
        int idx;
        if (live_offsets.size() == 0)
            send_alloc($urandom_range(200));
        else
        begin
            idx = $urandom_range(live_offsets.size() - 1);
            send_free(live_offsets[idx]);
            live_offsets.delete(idx);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        ffha_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t unexpected result", $time);
                error_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status != want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.payload_offset_out != want.payload_offset_out)
                    report_mismatch("offset", rsp.payload_offset_out, want.payload_offset_out);
                if (rsp.used_bytes != want.used_bytes)
                    report_mismatch("used", rsp.used_bytes, want.used_bytes);
                if (rsp.free_bytes != want.free_bytes)
                    report_mismatch("free", rsp.free_bytes, want.free_bytes);
            end
        end
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic test_directed();
        send_alloc(0);
        send_alloc(1);
        send_alloc(8191);
        send_alloc(4096);
        send_free(0);
        send_free(11);
        send_free(4096);
        send_free(8191);
        send_free(HEADER + 8);
        send_alloc(6);
        send_free(HEADER);
        send_free(HEADER);
        send_free(HEADER + 4 + HEADER);
        send_alloc(4000);
        send_alloc(64);
        send_alloc(4000);
        drain();
        while (live_offsets.size() != 0)
            free_random_live();
        send_alloc(POOL - HEADER);
        send_alloc(0);
        send_free(HEADER);
        send_alloc(POOL - 2 * HEADER - 4);
        send_free(HEADER);
        drain();
    endtask

    task automatic test_random(input int count);
        int unsigned pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_alloc($urandom_range(99) < 85 ? $urandom_range(300) : $urandom_range(8191));
            else if (pick < 85)
                free_random_live();
            else if (pick < 92 && live_offsets.size() != 0)
                send_free(live_offsets[$urandom_range(live_offsets.size() - 1)]);
            else
                send_free($urandom_range(8191));
        end
        drain();
    endtask

    task automatic test_release_all();
        while (live_offsets.size() != 0)
            free_random_live();
        drain();
    endtask

    initial
    begin
        clk           = 1'b0;
        error_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        pool_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(140);
        send_idle_pct = 85;
        test_random(130);
        send_idle_pct = 0;
        stall_pct = 85;
        test_random(130);
        send_idle_pct = 10;
        stall_pct = 10;
        test_random(130);
        test_release_all();
        stall_pct = 0;
        repeat (2000) @(posedge clk);
        if (error_count == 0 && pending_rsp.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
